@@ design/shd_pkg.sv @@
// Package for the double SHA-256 header nonce hasher.
// Holds the round constants, the initial hash values, the stage payload type,
// the register indexes and the SHA-256 helper functions. It depends on nothing else.
`default_nettype none

package shd_pkg;

    localparam int ROUNDS = 64;

    // SHA-256 round constants
    localparam logic [0:63][31:0] K_ROUND = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Standard initial hash values
    localparam logic [0:7][31:0] IV_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_WORD     = 32'h80000000;
    localparam logic [31:0] LEN_HEADER   = 32'(80 * 8);
    localparam logic [31:0] LEN_DIGEST   = 32'd256;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MID_01  = 3'd0,
        CFG_MID_23  = 3'd1,
        CFG_MID_45  = 3'd2,
        CFG_MID_67  = 3'd3,
        CFG_TAIL_01 = 3'd4,
        CFG_TAIL_2  = 3'd5,
        CFG_TARGET  = 3'd6
    } t_cfg_index;

    // Payload of one pipeline stage: working variables, schedule window, nonce.
    typedef struct packed {
        logic [0:7][31:0]  v;
        logic [0:15][31:0] w;
        logic [31:0]       nonce;
    } t_stage;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

`default_nettype wire

@@ design/sha256d_header_nonce_hasher_top.sv @@
// Top level of the double SHA-256 header nonce hasher.
// Depends on shd_pkg and shd_round_stage.
//
// Usage: write the midstate, the three header tail words and the share target
// through the configuration channel (index, data, valid/ready; ready is always
// high) while the block is idle. Then present one nonce per transfer on the input
// channel. Each nonce yields one transfer on the output channel with the eight
// final digest words, the nonce and the share flag, in input order.
//
// An item passes 130 register stages: 64 round stages for the header block, one
// stage that adds the midstate and builds the second message, 64 round stages
// for the digest block and the output register that adds the initial values and
// compares against the target. Throughput is one nonce per cycle while the
// receiver does not stall the output; every round is its own register stage.
//
// When the receiver stalls, the output holds and stages behind it keep filling
// empty slots; the input stall rises only once the whole pipeline is full.
// Reset clears all valid bits and all configuration registers to zero.
`default_nettype none

module sha256d_header_nonce_hasher_top
    import shd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_nonce,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_digest_words_0_1,
    output logic [63:0]      o_digest_words_2_3,
    output logic [63:0]      o_digest_words_4_5,
    output logic [63:0]      o_digest_words_6_7,
    output logic [31:0]      o_nonce_out,
    output logic             o_share_found
);

    logic [0:3][63:0] r_mid;
    logic [63:0]      r_tail01;
    logic [31:0]      r_tail2;
    logic [31:0]      r_target;

    t_stage a_data  [0:64];
    logic   a_valid [0:64];
    logic   a_rdy   [0:64];
    t_stage b_data  [0:64];
    logic   b_valid [0:64];
    logic   b_rdy   [0:64];

    t_stage n_fold;
    logic   r_fold_valid;
    t_stage r_fold;
    logic   w_fold_rdy;

    logic              r_out_valid;
    logic [0:7][31:0]  r_digest;
    logic [31:0]       r_nonce;
    logic              r_share;
    logic [0:7][31:0]  n_digest;
    logic              w_out_rdy;

    // Configuration writes; every transfer is accepted at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= '0;
            r_tail01 <= '0;
            r_tail2  <= '0;
            r_target <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MID_01:  r_mid[0] <= i_cfg_data;
                CFG_MID_23:  r_mid[1] <= i_cfg_data;
                CFG_MID_45:  r_mid[2] <= i_cfg_data;
                CFG_MID_67:  r_mid[3] <= i_cfg_data;
                CFG_TAIL_01: r_tail01 <= i_cfg_data;
                CFG_TAIL_2:  r_tail2  <= i_cfg_data[31:0];
                CFG_TARGET:  r_target <= i_cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // Header block message and midstate feed the first round.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            a_data[0].v[2 * j]     = r_mid[j][63:32];
            a_data[0].v[2 * j + 1] = r_mid[j][31:0];
        end
        a_data[0].w     = '0;
        a_data[0].w[0]  = r_tail01[63:32];
        a_data[0].w[1]  = r_tail01[31:0];
        a_data[0].w[2]  = r_tail2;
        a_data[0].w[3]  = i_nonce;
        a_data[0].w[4]  = PAD_WORD;
        a_data[0].w[15] = LEN_HEADER;
        a_data[0].nonce = i_nonce;
    end
    assign a_valid[0] = i_in_valid;
    assign o_in_stall = !a_rdy[0];

    // Rounds of the header block.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_blk1
        shd_round_stage u_round (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (a_valid[g]),
            .i_data       (a_data[g]),
            .i_k          (K_ROUND[g]),
            .i_next_ready (a_rdy[g + 1]),
            .o_valid      (a_valid[g + 1]),
            .o_data       (a_data[g + 1]),
            .o_ready      (a_rdy[g])
        );
    end
    assign a_rdy[ROUNDS] = w_fold_rdy;

    // Fold stage: add the midstate and build the padded digest message.
    always_comb begin
        n_fold.v = IV_HASH;
        n_fold.w = '0;
        for (int j = 0; j < 4; j++) begin
            n_fold.w[2 * j]     = r_mid[j][63:32] + a_data[ROUNDS].v[2 * j];
            n_fold.w[2 * j + 1] = r_mid[j][31:0] + a_data[ROUNDS].v[2 * j + 1];
        end
        n_fold.w[8]  = PAD_WORD;
        n_fold.w[15] = LEN_DIGEST;
        n_fold.nonce = a_data[ROUNDS].nonce;
    end

    assign w_fold_rdy = !r_fold_valid || b_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (w_fold_rdy) begin
            r_fold_valid <= a_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fold_rdy && a_valid[ROUNDS]) begin
            r_fold <= n_fold;
        end
    end

    assign b_data[0]  = r_fold;
    assign b_valid[0] = r_fold_valid;

    // Rounds of the digest block.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_blk2
        shd_round_stage u_round (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (b_valid[g]),
            .i_data       (b_data[g]),
            .i_k          (K_ROUND[g]),
            .i_next_ready (b_rdy[g + 1]),
            .o_valid      (b_valid[g + 1]),
            .o_data       (b_data[g + 1]),
            .o_ready      (b_rdy[g])
        );
    end
    assign b_rdy[ROUNDS] = w_out_rdy;

    // Output register: final addition and share check.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            n_digest[j] = IV_HASH[j] + b_data[ROUNDS].v[j];
        end
    end

    assign w_out_rdy = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= b_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && b_valid[ROUNDS]) begin
            r_digest <= n_digest;
            r_nonce  <= b_data[ROUNDS].nonce;
            r_share  <= (n_digest[7] == 32'd0) && (n_digest[6] <= r_target);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_digest_words_0_1 = {r_digest[0], r_digest[1]};
    assign o_digest_words_2_3 = {r_digest[2], r_digest[3]};
    assign o_digest_words_4_5 = {r_digest[4], r_digest[5]};
    assign o_digest_words_6_7 = {r_digest[6], r_digest[7]};
    assign o_nonce_out        = r_nonce;
    assign o_share_found      = r_share;

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid)
        else $error("output result dropped while stalled");

    // A share flag always comes with a zero digest word 7.
    a_share_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_share |-> r_digest[7] == 32'd0)
        else $error("share flag with nonzero digest word 7");

    // The input is stalled only when the first round stage holds an item and the output holds a stalled result.
    a_in_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> a_valid[1] && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // The fold stage holds its item while the digest block cannot take it.
    a_fold_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fold_valid && !b_rdy[0] |=> r_fold_valid && $stable(r_fold.nonce))
        else $error("fold stage lost an item");

endmodule

`default_nettype wire

@@ design/shd_round_stage.sv @@
// One registered SHA-256 round with its message schedule step.
// Uses shd_pkg for the payload type and the round functions.
`default_nettype none

module shd_round_stage
    import shd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_stage      i_data,
    input  wire logic [31:0] i_k,
    input  wire logic        i_next_ready,
    output logic             o_valid,
    output t_stage           o_data,
    output logic             o_ready
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_choose;
    logic [31:0] w_major;

    // The stage takes new data when it is empty or its content moves on.
    assign o_ready = !r_valid || i_next_ready;

    // Round function and schedule window shift.
    always_comb begin
        w_choose = (i_data.v[4] & i_data.v[5]) ^ (~i_data.v[4] & i_data.v[6]);
        w_major  = (i_data.v[0] & i_data.v[1]) ^ (i_data.v[0] & i_data.v[2])
                 ^ (i_data.v[1] & i_data.v[2]);
        w_t1 = i_data.v[7] + bsig1(i_data.v[4]) + w_choose + i_k + i_data.w[0];
        w_t2 = bsig0(i_data.v[0]) + w_major;
        n_data.v[0] = w_t1 + w_t2;
        n_data.v[1] = i_data.v[0];
        n_data.v[2] = i_data.v[1];
        n_data.v[3] = i_data.v[2];
        n_data.v[4] = i_data.v[3] + w_t1;
        n_data.v[5] = i_data.v[4];
        n_data.v[6] = i_data.v[5];
        n_data.v[7] = i_data.v[6];
        for (int j = 0; j < 15; j++) begin
            n_data.w[j] = i_data.w[j + 1];
        end
        n_data.w[15] = i_data.w[0] + sig0(i_data.w[1]) + i_data.w[9] + sig1(i_data.w[14]);
        n_data.nonce = i_data.nonce;
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
